/* design/tsc_pkg.sv */
// Shared types and constants for the touch sample conditioner.
// No dependencies; every other design file uses this package.
package tsc_pkg;

  // Converter resolution and derived widths
  localparam int ADC_BITS = 10;
  localparam int SAMPLE_W = 10;                // width of a sample field
  localparam int COORD_W  = ADC_BITS + 1;      // holds full scale after inversion
  localparam int POS_W    = 11;                // width of a reported coordinate
  localparam int MIN_W    = 10;
  localparam int WIN_W    = 8;
  localparam int TICK_W   = 32;
  localparam int CMP_W    = (COORD_W > MIN_W) ? COORD_W : MIN_W;
  localparam int WORK_W   = (COORD_W > POS_W) ? COORD_W : POS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [COORD_W-1:0] FULL_SCALE = COORD_W'(1) << ADC_BITS;
  localparam logic [MIN_W-1:0]   MIN_COORD_RST     = MIN_W'(16);
  localparam logic [WIN_W-1:0]   SMOOTH_WINDOW_RST = WIN_W'(2);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWAP_AXES     = 3'd0,
    CFG_INVERT_X      = 3'd1,
    CFG_INVERT_Y      = 3'd2,
    CFG_MIN_COORD     = 3'd3,
    CFG_SMOOTH_WINDOW = 3'd4
  } cfg_idx_e;

  // Item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  typedef struct packed {
    logic                swap_axes;
    logic                invert_x;
    logic                invert_y;
    logic [MIN_W-1:0]    min_coord;
    logic [WIN_W-1:0]    smooth_window;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic                detect_level;
    logic                hold_key;
    logic [SAMPLE_W-1:0] first_sample_a;
    logic [SAMPLE_W-1:0] first_sample_b;
    logic [SAMPLE_W-1:0] second_sample_a;
    logic [SAMPLE_W-1:0] second_sample_b;
    logic                detect_after;
    logic [TICK_W-1:0]   tick_now;
  } in_item_t;

  typedef struct packed {
    logic             pressed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } out_item_t;

  // Conditioned point from the sample datapath
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               reject;
  } point_t;

endpackage

/* design/touch_sample_conditioner_core.sv */
// Top level of the touch sample conditioner: input register, pen tracking,
// smoothing and result register. Depends on tsc_pkg, tsc_cfg and tsc_cond.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries pen-detect
//   edge events and poll ticks with two readings per measurement channel.
//   Output channel (out_valid_o / out_stall_i / out_item_o) carries press
//   reports with coordinates and release reports with zero coordinates.
//   An item is taken on a clock edge with valid high and stall low.
//   Each input item gives zero or one result item.
//
//   Flow: an item is registered in the input register on acceptance, is
//   processed there against the pen state and the previous point, and its
//   result is then registered in the output register.
//   Throughput: one item per cycle while no result waits on a stalled
//   output; the pen/previous-point state is updated in the same cycle the
//   item leaves the input register, so the next item sees it with no bubble.
//
//   Reset (rst_ni low, asynchronous): both channels empty, pen up, previous
//   point and tick cleared, registers at their defaults.
//   Stall: while the output register holds an undelivered result and the
//   receiver stalls, an item that would produce a result waits in the input
//   register and in_stall_o rises; items that give no result still pass.
//   Configuration writes are meant for idle periods only.
module touch_sample_conditioner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tsc_pkg::in_item_t               in_item_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tsc_pkg::out_item_t              out_item_o
);

  tsc_pkg::cfg_t     cfg;
  tsc_pkg::point_t   point;

  // input register
  logic              s1_valid_q, s1_valid_d;
  tsc_pkg::in_item_t s1_item_q;

  // tracked state
  logic                       pen_q, pen_d;
  logic [tsc_pkg::POS_W-1:0]  prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [tsc_pkg::TICK_W-1:0] prev_tick_q, prev_tick_d;

  // output register
  logic               out_valid_q, out_valid_d;
  tsc_pkg::out_item_t out_item_q, out_item_d;

  // decision signals
  logic               res_valid;
  tsc_pkg::out_item_t res_item;
  logic               s1_fire;
  logic [tsc_pkg::TICK_W-1:0]  tick_delta;
  logic                        in_window;
  logic [tsc_pkg::WORK_W:0]    sum_x, sum_y;
  logic [tsc_pkg::POS_W-1:0]   new_x, new_y;

  tsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tsc_cond u_cond (
    .item_i  (s1_item_q),
    .cfg_i   (cfg),
    .point_o (point)
  );

  // smoothing against the previous accepted point; tick distance wraps
  always_comb begin
    tick_delta = s1_item_q.tick_now - prev_tick_q;
    in_window  = tick_delta < tsc_pkg::TICK_W'(cfg.smooth_window);
    sum_x = tsc_pkg::WORK_W'(prev_x_q) + tsc_pkg::WORK_W'(point.x) + (tsc_pkg::WORK_W+1)'(0);
    sum_y = tsc_pkg::WORK_W'(prev_y_q) + tsc_pkg::WORK_W'(point.y) + (tsc_pkg::WORK_W+1)'(0);
    if (in_window) begin
      new_x = tsc_pkg::POS_W'(sum_x >> 1);
      new_y = tsc_pkg::POS_W'(sum_y >> 1);
    end else begin
      new_x = tsc_pkg::POS_W'(point.x);
      new_y = tsc_pkg::POS_W'(point.y);
    end
  end

  // pen tracking and report decision for the item in the input register
  always_comb begin
    res_valid   = 1'b0;
    res_item    = '0;
    pen_d       = pen_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    prev_tick_d = prev_tick_q;
    if (s1_item_q.kind == tsc_pkg::KIND_EDGE) begin
      if (!pen_q) begin
        if (!s1_item_q.detect_level) pen_d = 1'b1;
      end else if (s1_item_q.detect_level) begin
        pen_d     = 1'b0;
        res_valid = 1'b1;     // release
      end
    end else if (pen_q) begin
      if (s1_item_q.detect_level || s1_item_q.hold_key) begin
        pen_d     = 1'b0;
        res_valid = 1'b1;     // release, pen lifted or hold switch
      end else if (point.reject) begin
        res_valid = 1'b1;     // release, point rejected (out of range or detect_after set); state kept
      end else begin
        res_valid        = 1'b1;
        res_item.pressed = 1'b1;
        res_item.pos_x   = new_x;
        res_item.pos_y   = new_y;
        prev_x_d         = new_x;
        prev_y_d         = new_y;
        prev_tick_d      = s1_item_q.tick_now;
      end
    end
  end

  // item leaves the input register unless its result would hit a full,
  // stalled output register
  assign s1_fire    = s1_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (s1_fire && res_valid) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pen_q       <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_tick_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        pen_q       <= pen_d;
        prev_x_q    <= prev_x_d;
        prev_y_q    <= prev_y_d;
        prev_tick_q <= prev_tick_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o) s1_item_q <= in_item_i;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* design/tsc_cfg.sv */
// Configuration register file for the touch sample conditioner.
// Depends on tsc_pkg.
module tsc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output tsc_pkg::cfg_t                   cfg_o
);

  tsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tsc_pkg::CFG_SWAP_AXES:     cfg_d.swap_axes     = cfg_wdata_i[0];
        tsc_pkg::CFG_INVERT_X:      cfg_d.invert_x      = cfg_wdata_i[0];
        tsc_pkg::CFG_INVERT_Y:      cfg_d.invert_y      = cfg_wdata_i[0];
        tsc_pkg::CFG_MIN_COORD:     cfg_d.min_coord     = cfg_wdata_i[tsc_pkg::MIN_W-1:0];
        tsc_pkg::CFG_SMOOTH_WINDOW: cfg_d.smooth_window = cfg_wdata_i[tsc_pkg::WIN_W-1:0];
        default:                    cfg_d = cfg_q;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swap_axes     <= 1'b0;
      cfg_q.invert_x      <= 1'b0;
      cfg_q.invert_y      <= 1'b0;
      cfg_q.min_coord     <= tsc_pkg::MIN_COORD_RST;
      cfg_q.smooth_window <= tsc_pkg::SMOOTH_WINDOW_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/tsc_cond.sv */
// Sample datapath: pair averaging, axis swap, inversion and range check.
// Purely combinational. Depends on tsc_pkg.
module tsc_cond (
  input  tsc_pkg::in_item_t item_i,
  input  tsc_pkg::cfg_t     cfg_i,
  output tsc_pkg::point_t   point_o
);

  logic [tsc_pkg::ADC_BITS-1:0] fa, fb, sa, sb;
  logic [tsc_pkg::ADC_BITS:0]   sum_first, sum_second;
  logic [tsc_pkg::COORD_W-1:0]  first, second, x_raw, y_raw, x, y;
  logic [tsc_pkg::CMP_W-1:0]    x_cmp, y_cmp, min_cmp;

  always_comb begin
    fa = tsc_pkg::ADC_BITS'(item_i.first_sample_a);
    fb = tsc_pkg::ADC_BITS'(item_i.first_sample_b);
    sa = tsc_pkg::ADC_BITS'(item_i.second_sample_a);
    sb = tsc_pkg::ADC_BITS'(item_i.second_sample_b);

    // truncating average of each pair
    sum_first  = {1'b0, fa} + {1'b0, fb};
    sum_second = {1'b0, sa} + {1'b0, sb};
    first  = tsc_pkg::COORD_W'(sum_first[tsc_pkg::ADC_BITS:1]);
    second = tsc_pkg::COORD_W'(sum_second[tsc_pkg::ADC_BITS:1]);

    x_raw = cfg_i.swap_axes ? second : first;
    y_raw = cfg_i.swap_axes ? first  : second;
    x = cfg_i.invert_x ? (tsc_pkg::FULL_SCALE - x_raw) : x_raw;
    y = cfg_i.invert_y ? (tsc_pkg::FULL_SCALE - y_raw) : y_raw;

    x_cmp   = tsc_pkg::CMP_W'(x);
    y_cmp   = tsc_pkg::CMP_W'(y);
    min_cmp = tsc_pkg::CMP_W'(cfg_i.min_coord);

    point_o.x      = x;
    point_o.y      = y;
    point_o.reject = (x_cmp < min_cmp) || (y_cmp < min_cmp) || item_i.detect_after;
  end

endmodule
